[hw/rtl/kft_pkg.sv]
package kft_pkg;

  // fixed field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned BLEND_W    = 16;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'd1;

  // item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // divider request: dividend is the elapsed time inside the frame, below den
  typedef struct packed {
    logic              go;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [BLEND_W-1:0] quot;
  } div_res_t;

endpackage

[hw/rtl/keyframe_time_lookup.sv]
// Keyframe time lookup.
// Input channel: an item is taken when start is high and busy is low. A write
// beat (action low) stores frame_length into table entry slot in that same
// edge; busy stays low, so another item may follow in the next cycle. Slots
// at or above MAX_FRAMES are dropped.
// A query beat (action high) walks the duration table from frame 0, one
// memory read per cycle, adding up start times until a frame holds
// query_time, the walk runs past the time, or frame_count frames (at most
// MAX_FRAMES) are done. A hit runs a restoring divider for the blend
// factor, except a hit on the last frame with loop_enable low, which
// answers with both frames set to that frame and blend_factor zero.
// Result channel: done pulses for one cycle with found, first_frame,
// second_frame and blend_factor; the receiver has no way to stall it.
// A query with frame_count zero answers straight from idle with found low.
// The next item is accepted in the cycle done is shown.
// Reset clears the control state and both configuration registers; the
// table contents stay undefined until written.
module keyframe_time_lookup #(
  parameter int unsigned MAX_FRAMES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [kft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kft_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic [kft_pkg::FRAME_W-1:0]       slot,
  input  logic [kft_pkg::TIME_W-1:0]        frame_length,
  input  logic [kft_pkg::TIME_W-1:0]        query_time,
  output logic                              done,
  output logic                              found,
  output logic [kft_pkg::FRAME_W-1:0]       first_frame,
  output logic [kft_pkg::FRAME_W-1:0]       second_frame,
  output logic [kft_pkg::BLEND_W-1:0]       blend_factor
);

  localparam int unsigned AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_R = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CNTW  = (CNT_R > kft_pkg::COUNT_W) ? CNT_R : kft_pkg::COUNT_W;
  localparam int unsigned TW    = kft_pkg::TIME_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DIV
  } state_t;

  state_t                        state;
  logic [kft_pkg::COUNT_W-1:0]   frame_count;
  logic                          loop_enable;
  logic [TW-1:0]                 qtime;
  logic [TW:0]                   start_acc;
  logic [AW-1:0]                 cur;
  logic [kft_pkg::FRAME_W-1:0]   hit_frame;
  logic [kft_pkg::FRAME_W-1:0]   hit_next;
  kft_pkg::div_req_t             div_req;
  kft_pkg::div_res_t             div_res;

  logic [TW-1:0]                 table_mem [MAX_FRAMES];
  logic [TW-1:0]                 rdata;
  logic [AW-1:0]                 rd_addr;

  logic                          accept;
  logic                          wr_en;
  logic [CNTW-1:0]               count_eff;
  logic [CNTW-1:0]               count_m1;
  logic                          cur_last;
  logic [TW:0]                   end_time;
  logic                          past_time;
  logic                          hit;
  logic [kft_pkg::FRAME_W-1:0]   cur_frame;

  // input handshake and table write
  assign accept = start && !busy;
  assign wr_en  = accept && (action == kft_pkg::ACT_WRITE)
                  && (32'(slot) < 32'(MAX_FRAMES));
  assign busy   = (state != S_IDLE);

  // walk bookkeeping
  always_comb begin
    count_eff = (CNTW'(frame_count) > CNTW'(MAX_FRAMES)) ? CNTW'(MAX_FRAMES)
                                                          : CNTW'(frame_count);
    count_m1  = count_eff - 1'b1;
    cur_last  = (CNTW'(cur) == count_m1);
    end_time  = start_acc + {1'b0, rdata};
    past_time = (start_acc > {1'b0, qtime});
    hit       = !past_time && (rdata != '0) && ({1'b0, qtime} < end_time);
    cur_frame = kft_pkg::FRAME_W'(cur);
  end

  // read address runs one entry ahead of the entry being checked
  always_comb begin
    if (state == S_WALK) begin
      rd_addr = (32'(cur) == 32'(MAX_FRAMES - 1)) ? '0 : cur + 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  // duration table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[AW'(slot)] <= frame_length;
    end
    rdata <= table_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      loop_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        kft_pkg::CFG_FRAME_COUNT: frame_count <= cfg_data;
        kft_pkg::CFG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // query sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      div_req.go <= 1'b0;
    end else begin
      done       <= 1'b0;
      div_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (action == kft_pkg::ACT_QUERY)) begin
            qtime     <= query_time;
            start_acc <= '0;
            cur       <= '0;
            if (count_eff == '0) begin
              done         <= 1'b1;
              found        <= 1'b0;
              first_frame  <= '0;
              second_frame <= '0;
              blend_factor <= '0;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (hit) begin
            if (cur_last && !loop_enable) begin
              done         <= 1'b1;
              found        <= 1'b1;
              first_frame  <= cur_frame;
              second_frame <= cur_frame;
              blend_factor <= '0;
              state        <= S_IDLE;
            end else begin
              hit_frame   <= cur_frame;
              hit_next    <= cur_last ? '0 : cur_frame + 1'b1;
              div_req.go  <= 1'b1;
              div_req.num <= qtime - start_acc[TW-1:0];
              div_req.den <= rdata;
              state       <= S_DIV;
            end
          end else if (past_time || cur_last) begin
            done         <= 1'b1;
            found        <= 1'b0;
            first_frame  <= '0;
            second_frame <= '0;
            blend_factor <= '0;
            state        <= S_IDLE;
          end else begin
            start_acc <= end_time;
            cur       <= cur + 1'b1;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            done         <= 1'b1;
            found        <= 1'b1;
            first_frame  <= hit_frame;
            second_frame <= hit_next;
            blend_factor <= div_res.quot;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // blend factor divider
  kft_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

endmodule

[hw/rtl/kft_divider.sv]
module kft_divider (
  input  logic             clk,
  input  logic             rst,
  input  kft_pkg::div_req_t req,
  output kft_pkg::div_res_t res
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  localparam int unsigned STEP_W = $clog2(kft_pkg::BLEND_W);

  state_t                        state;
  logic [STEP_W-1:0]             step;
  logic [kft_pkg::TIME_W-1:0]    rem;
  logic [kft_pkg::TIME_W-1:0]    den;
  logic [kft_pkg::BLEND_W-1:0]   quot;
  logic                          done;
  logic [kft_pkg::TIME_W:0]      rem_shift;
  logic                          take;
  logic [kft_pkg::TIME_W:0]      rem_diff;

  // one restoring step: shift in a zero, subtract the divisor if it fits
  always_comb begin
    rem_shift = {rem, 1'b0};
    take      = (rem_shift >= {1'b0, den});
    rem_diff  = rem_shift - {1'b0, den};
  end

  // iteration control, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.go) begin
            rem   <= req.num;
            den   <= req.den;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (take) begin
            rem <= rem_diff[kft_pkg::TIME_W-1:0];
          end else begin
            rem <= rem_shift[kft_pkg::TIME_W-1:0];
          end
          quot <= {quot[kft_pkg::BLEND_W-2:0], take};
          step <= step + 1'b1;
          if (step == STEP_W'(kft_pkg::BLEND_W - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res = '{done: done, quot: quot};

endmodule

[hw/rtl/kft_checker.sv]
module kft_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            action,
  input logic                            done,
  input logic                            found,
  input logic [kft_pkg::FRAME_W-1:0]     first_frame,
  input logic [kft_pkg::FRAME_W-1:0]     second_frame,
  input logic [kft_pkg::BLEND_W-1:0]     blend_factor
);

  // a write beat never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == kft_pkg::ACT_WRITE)) |=> !done)
    else $error("result after a write beat");

  // results are single-cycle pulses unless a query beat is taken meanwhile
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    (done && !(start && !busy && (action == kft_pkg::ACT_QUERY))) |=> !done)
    else $error("result strobe held for two cycles");

  // the block is free again when it shows a result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a miss carries zeroed fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> ((first_frame == '0) && (second_frame == '0)
                          && (blend_factor == '0)))
    else $error("miss result with nonzero fields");

endmodule

bind keyframe_time_lookup kft_checker u_kft_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .found        (found),
  .first_frame  (first_frame),
  .second_frame (second_frame),
  .blend_factor (blend_factor)
);
